FILE: hdl/wbps_pkg.sv
package wbps_pkg;

    // Pattern bytes held in the configuration registers
    localparam int unsigned REG_PATTERN_BYTES = 16;

    // Configuration port widths
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    // Field widths
    localparam int unsigned CARE_W    = 16;
    localparam int unsigned PLEN_W    = 5;
    localparam int unsigned WINDOW_W  = 32;
    localparam int unsigned MATCH_W   = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_START     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT     = 3'd5;

    // Register reset values
    localparam logic [CARE_W-1:0]   CARE_RESET  = 16'hFFFF;
    localparam logic [PLEN_W-1:0]   PLEN_RESET  = 5'd1;
    localparam logic [WINDOW_W-1:0] LIMIT_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [MATCH_W-1:0] match_offset;
    } t_out_item;

endpackage

FILE: hdl/wildcard_byte_pattern_scan_core.sv
// A byte is taken into the input register; its result goes from the window
// compare into the result register. Throughput: one byte per cycle while the
// result register is free or being read, set by the combinational masked window
// compare. While a result waits, the input side takes at most one byte, into the
// input register. Reset (synchronous, active low) restores the register defaults
// and clears the byte window, the offset counter and the match flag.
module wildcard_byte_pattern_scan_core #(
    parameter int unsigned MAX_PATTERN_BYTES = 16,
    parameter int unsigned OFFSET_BITS       = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // byte stream in
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  wbps_pkg::t_in_item                  i_in,
    // results out
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wbps_pkg::t_out_item                 o_out
);

    localparam int unsigned IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int unsigned CW = IW + 5;
    localparam int unsigned SW = (OFFSET_BITS > wbps_pkg::WINDOW_W) ?
                                 OFFSET_BITS : wbps_pkg::WINDOW_W;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam int unsigned NPAT = wbps_pkg::REG_PATTERN_BYTES;

    // configuration registers
    logic [63:0]                       r_pat_low;
    logic [63:0]                       r_pat_high;
    logic [wbps_pkg::CARE_W-1:0]       r_care;
    logic [wbps_pkg::PLEN_W-1:0]       r_plen;
    logic [wbps_pkg::WINDOW_W-1:0]     r_scan_start;
    logic [wbps_pkg::WINDOW_W-1:0]     r_scan_limit;

    // input stage
    logic                              r_in_valid;
    wbps_pkg::t_in_item                r_in;

    // region state
    logic [7:0]                        r_win [MAX_PATTERN_BYTES];
    logic [7:0]                        n_win [MAX_PATTERN_BYTES];
    logic [OFFSET_BITS-1:0]            r_pos;
    logic [OFFSET_BITS-1:0]            n_pos;
    logic                              r_done;
    logic                              n_done;

    // result stage
    logic                              r_out_valid;
    wbps_pkg::t_out_item               r_out;
    wbps_pkg::t_out_item               n_out;

    logic                              stage_go;
    logic                              has_result;
    logic [CW-1:0]                     len_c;
    logic [CW-1:0]                     len_m1_c;
    logic [IW-1:0]                     len_m1;
    logic [OFFSET_BITS-1:0]            start;
    logic [SW-1:0]                     start_ext;
    logic                              counter_full;
    logic                              pos_ok;
    logic                              in_range;
    logic                              hit;
    logic                              res_found;
    logic                              res_nf;
    logic [127:0]                      pat_all;

    // handshake: the input register moves on whenever the result register is free
    assign stage_go    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || stage_go;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low    <= '0;
            r_pat_high   <= '0;
            r_care       <= wbps_pkg::CARE_RESET;
            r_plen       <= wbps_pkg::PLEN_RESET;
            r_scan_start <= '0;
            r_scan_limit <= wbps_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wbps_pkg::CFG_PATTERN_LOW: begin
                    r_pat_low <= i_cfg_data;
                end
                wbps_pkg::CFG_PATTERN_HIGH: begin
                    r_pat_high <= i_cfg_data;
                end
                wbps_pkg::CFG_CARE_MASK: begin
                    r_care <= i_cfg_data[wbps_pkg::CARE_W-1:0];
                end
                wbps_pkg::CFG_PATTERN_LENGTH: begin
                    r_plen <= i_cfg_data[wbps_pkg::PLEN_W-1:0];
                end
                wbps_pkg::CFG_SCAN_START: begin
                    r_scan_start <= i_cfg_data[wbps_pkg::WINDOW_W-1:0];
                end
                wbps_pkg::CFG_SCAN_LIMIT: begin
                    r_scan_limit <= i_cfg_data[wbps_pkg::WINDOW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective pattern length: zero counts as one, saturate at the window depth
    always_comb begin
        len_c = CW'(r_plen);
        if (len_c == '0) begin
            len_c = CW'(1);
        end
        if (len_c > CW'(MAX_PATTERN_BYTES)) begin
            len_c = CW'(MAX_PATTERN_BYTES);
        end
        len_m1_c = len_c - CW'(1);
        len_m1   = len_m1_c[IW-1:0];
    end

    // window after the new byte shifts in
    always_comb begin
        n_win[0] = r_in.data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    // offset checks
    assign counter_full = (r_pos == OFFSET_MAX);
    assign pos_ok       = (r_pos >= OFFSET_BITS'(len_m1));
    assign start        = r_pos - OFFSET_BITS'(len_m1);
    assign start_ext    = SW'(start);
    assign in_range     = (start_ext >= SW'(r_scan_start)) && (start_ext < SW'(r_scan_limit));

    // masked byte compare; pattern byte i lines up with window slot len-1-i
    assign pat_all = {r_pat_high, r_pat_low};
    always_comb begin
        logic [CW-1:0] slot;
        hit = 1'b1;
        for (int i = 0; i < NPAT; i++) begin
            slot = len_m1_c - CW'(i);
            if ((CW'(i) <= len_m1_c) && r_care[i]) begin
                if (pat_all[8*i +: 8] != n_win[slot[IW-1:0]]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    // result and next region state
    always_comb begin
        res_found  = !r_done && !counter_full && pos_ok && in_range && hit;
        res_nf     = r_in.region_end && !res_found && !r_done;
        has_result = res_found || res_nf;

        n_out.found        = res_found;
        n_out.match_offset = res_found ? start_ext[wbps_pkg::MATCH_W-1:0] : '0;

        if (r_in.region_end) begin
            n_pos  = '0;
            n_done = 1'b0;
        end else begin
            n_pos  = counter_full ? r_pos : r_pos + OFFSET_BITS'(1);
            n_done = r_done || res_found;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // region state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_done <= 1'b0;
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
                r_win[k] <= '0;
            end
        end else if (stage_go) begin
            r_pos  <= n_pos;
            r_done <= n_done;
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
                r_win[k] <= r_in.region_end ? 8'h00 : n_win[k];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (stage_go && has_result) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int MAX_PAT        = 16;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    logic                            i_clk     = 1'b0;
    logic                            i_rst_n   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    wbps_pkg::t_in_item              in_item   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    wbps_pkg::t_out_item             out_item;

    wildcard_byte_pattern_scan_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the configuration registers
    logic [63:0]                   cfg_pat_lo = '0;
    logic [63:0]                   cfg_pat_hi = '0;
    logic [wbps_pkg::CARE_W-1:0]   cfg_care   = wbps_pkg::CARE_RESET;
    logic [wbps_pkg::PLEN_W-1:0]   cfg_plen   = wbps_pkg::PLEN_RESET;
    logic [wbps_pkg::WINDOW_W-1:0] cfg_start  = '0;
    logic [wbps_pkg::WINDOW_W-1:0] cfg_limit  = wbps_pkg::LIMIT_RESET;

    // Scanner state as the predictor sees it
    logic [7:0]  recent_bytes [MAX_PAT];
    logic [31:0] offs_cnt   = '0;
    logic        region_hit = 1'b0;

    wbps_pkg::t_in_item  byte_q [$];
    wbps_pkg::t_out_item report_q [$];
    int          bytes_queued = 0;
    int          bytes_taken  = 0;
    int          mismatches   = 0;

    logic        in_took  = 1'b0;
    logic        out_took = 1'b0;
    logic        no_idle  = 1'b0;
    logic        long_hold_go   = 1'b0;
    logic        long_hold_done = 1'b0;
    int          send_gap  = 0;
    int          hold_left = 0;
    int          wait_left = 0;
    int          idle_cycles = 0;

    function automatic int eff_len();
        if (cfg_plen == 0)
            return 1;
        if (cfg_plen > MAX_PAT)
            return MAX_PAT;
        return int'(cfg_plen);
    endfunction

    function automatic logic [7:0] pat_byte_at(int i);
        if (i < 8)
            return cfg_pat_lo[8*i +: 8];
        return cfg_pat_hi[8*(i-8) +: 8];
    endfunction

    // Predict the report (if any) caused by one byte transfer
    task automatic scan_byte(input wbps_pkg::t_in_item it);
        logic [31:0] pos;
        logic [31:0] span;
        logic [31:0] st;
        logic        full;
        logic        hit;
        logic        got;
        int          len;
        wbps_pkg::t_out_item r;
        pos  = offs_cnt;
        full = (pos == 32'hFFFF_FFFF);
        len  = eff_len();
        span = 32'(len - 1);
        got  = 1'b0;
        for (int k = MAX_PAT - 1; k > 0; k--)
            recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = it.data_byte;
        if (!full)
            offs_cnt = pos + 1;
        if (!region_hit && !full && pos >= span) begin
            st = pos - span;
            if (st >= cfg_start && st < cfg_limit) begin
                hit = 1'b1;
                for (int i = 0; i < len; i++)
                    if (cfg_care[i] && pat_byte_at(i) != recent_bytes[len-1-i])
                        hit = 1'b0;
                if (hit) begin
                    region_hit     = 1'b1;
                    r.found        = 1'b1;
                    r.match_offset = st;
                    report_q       = {report_q, r};
                    got = 1'b1;
                end
            end
        end
        if (it.region_end) begin
            if (!got && !region_hit) begin
                r.found        = 1'b0;
                r.match_offset = '0;
                report_q       = {report_q, r};
            end
            foreach (recent_bytes[k])
                recent_bytes[k] = '0;
            offs_cnt   = '0;
            region_hit = 1'b0;
        end
    endtask

    // Register write; only issued while the block is idle
    task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            wbps_pkg::CFG_PATTERN_LOW:    cfg_pat_lo = val;
            wbps_pkg::CFG_PATTERN_HIGH:   cfg_pat_hi = val;
            wbps_pkg::CFG_CARE_MASK:      cfg_care   = val[wbps_pkg::CARE_W-1:0];
            wbps_pkg::CFG_PATTERN_LENGTH: cfg_plen   = val[wbps_pkg::PLEN_W-1:0];
            wbps_pkg::CFG_SCAN_START:     cfg_start  = val[wbps_pkg::WINDOW_W-1:0];
            wbps_pkg::CFG_SCAN_LIMIT:     cfg_limit  = val[wbps_pkg::WINDOW_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        wbps_pkg::t_in_item it;
        it.data_byte  = b;
        it.region_end = last;
        byte_q = {byte_q, it};
        bytes_queued++;
    endtask

    // Wait until every byte is taken and every report seen, then let the pipe empty
    task automatic settle();
        do @(negedge i_clk);
        while (bytes_taken != bytes_queued || report_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One region: noise biased toward pattern bytes, usually with an embedded copy
    task automatic queue_region();
        logic [7:0] rb [$];
        logic [7:0] nb;
        int         len;
        int         rlen;
        int         lo;
        int         p;
        len = eff_len();
        case ($urandom_range(0, 9))
            0:       rlen = $urandom_range(60, 140);
            1:       rlen = $urandom_range(1, len);
            default: rlen = $urandom_range(len, 2 * len + 10);
        endcase
        for (int j = 0; j < rlen; j++) begin
            nb = $urandom_range(0, 1) ? pat_byte_at($urandom_range(0, len - 1))
                                      : 8'($urandom);
            rb = {rb, nb};
        end
        if (rlen >= len && $urandom_range(0, 3) != 0) begin
            lo = (cfg_start <= 200) ? int'(cfg_start) : 0;
            if (lo > rlen - len)
                lo = 0;
            p = $urandom_range(lo, rlen - len);
            for (int i = 0; i < len; i++)
                if (cfg_care[i])
                    rb[p+i] = pat_byte_at(i);
            if ($urandom_range(0, 4) == 0)
                rb[p + $urandom_range(0, len - 1)] = 8'($urandom);
        end
        for (int j = 0; j < rlen; j++)
            push_byte(rb[j], (j == rlen - 1) || ($urandom_range(0, 59) == 0));
    endtask

    task automatic random_phase(input int n);
        logic [63:0] v;
        logic [31:0] st;
        int          target;
        no_idle = ($urandom_range(0, 3) == 0);
        for (int h = 0; h < 2; h++) begin
            case ($urandom_range(0, 7))
                0:       v = '0;
                1:       v = '1;
                default: v = {$urandom, $urandom};
            endcase
            write_reg(h == 0 ? wbps_pkg::CFG_PATTERN_LOW : wbps_pkg::CFG_PATTERN_HIGH, v);
        end
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v[15:0] = 16'hFFFF;
            1: v[15:0] = 16'h0000;
            default: ;
        endcase
        write_reg(wbps_pkg::CFG_CARE_MASK, v);
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v[4:0] = 5'd0;
            1:       v[4:0] = 5'($urandom_range(17, 31));
            2:       v[4:0] = 5'd16;
            default: v[4:0] = 5'($urandom_range(1, 16));
        endcase
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, v);
        case ($urandom_range(0, 8))
            6:       st = '0;
            7:       st = $urandom;
            8:       st = 32'hFFFF_FFFF;
            default: st = $urandom_range(0, 8);
        endcase
        write_reg(wbps_pkg::CFG_SCAN_START, {$urandom, st});
        case ($urandom_range(0, 9))
            5, 6:    v[31:0] = st + $urandom_range(1, 40);
            7:       v[31:0] = '0;
            8:       v[31:0] = $urandom;
            9:       v[31:0] = st;
            default: v[31:0] = 32'hFFFF_FFFF;
        endcase
        v[63:32] = $urandom;
        write_reg(wbps_pkg::CFG_SCAN_LIMIT, v);
        target = bytes_queued + n;
        while (bytes_queued < target)
            queue_region();
        settle();
    endtask

    // Sender: one transfer at a time, random gap after each
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (byte_q.size() != 0) begin
                in_item  <= byte_q.pop_front();
                in_valid <= 1'b1;
                send_gap <= no_idle ? 0 : $urandom_range(0, 4);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall per result, plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (long_hold_go && !long_hold_done) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (out_took)
                wait_left = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: check result transfers, predict on byte transfers
    always @(posedge i_clk) begin
        in_took  <= i_rst_n && in_valid && in_ready;
        out_took <= i_rst_n && out_valid && out_ready;
        if (i_rst_n && out_valid && out_ready) begin : chk
            wbps_pkg::t_out_item want;
            if (report_q.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: unexpected result found=%0b offset=%0d",
                             out_item.found, out_item.match_offset);
                mismatches++;
            end else begin
                want = report_q.pop_front();
                if (out_item.found !== want.found ||
                    out_item.match_offset !== want.match_offset) begin
                    if (mismatches < 10)
                        $display("ERROR: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                                 want.found, want.match_offset,
                                 out_item.found, out_item.match_offset);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && in_valid && in_ready) begin
            scan_byte(in_item);
            bytes_taken++;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("wildcard_byte_pattern_scan_core verification failed");
            $finish;
        end
    end

    initial begin
        foreach (recent_bytes[k])
            recent_bytes[k] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset config: single byte 0x00, all cares
        push_byte(8'h55, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);   // end of a region that already matched
        push_byte(8'h00, 1'b1);   // match on the final byte
        settle();

        // "A B ? D" with the third byte as wildcard
        write_reg(wbps_pkg::CFG_PATTERN_LOW, {32'h0, 8'h44, 8'h2A, 8'h42, 8'h41});
        write_reg(wbps_pkg::CFG_PATTERN_HIGH, '1);
        write_reg(wbps_pkg::CFG_CARE_MASK, 64'hFFFB);
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd4);
        write_reg(wbps_pkg::CFG_SCAN_START, 64'd0);
        write_reg(wbps_pkg::CFG_SCAN_LIMIT, 64'hFFFF_FFFF);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h44, 1'b1);
        settle();

        // Empty care mask, length zero, narrow offset window
        write_reg(wbps_pkg::CFG_CARE_MASK, 64'h0);
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd0);
        write_reg(wbps_pkg::CFG_SCAN_START, 64'd2);
        write_reg(wbps_pkg::CFG_SCAN_LIMIT, 64'd3);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        settle();

        // Start not below limit: nothing can match
        write_reg(wbps_pkg::CFG_SCAN_START, 64'hFFFF_FFFF);
        write_reg(wbps_pkg::CFG_SCAN_LIMIT, 64'h0);
        push_byte(8'h12, 1'b1);
        settle();

        // Oversized length saturates to the full window
        write_reg(wbps_pkg::CFG_PATTERN_LOW, '1);
        write_reg(wbps_pkg::CFG_CARE_MASK, 64'hFFFF);
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd31);
        write_reg(wbps_pkg::CFG_SCAN_START, 64'd0);
        write_reg(wbps_pkg::CFG_SCAN_LIMIT, 64'hFFFF_FFFF);
        for (int j = 0; j < MAX_PAT; j++)
            push_byte(8'hFF, j == MAX_PAT - 1);
        settle();

        // Back-pressure: every byte reports while the receiver holds off
        no_idle = 1'b0;
        write_reg(wbps_pkg::CFG_CARE_MASK, 64'h0);
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd1);
        long_hold_go = 1'b1;
        for (int j = 0; j < 80; j++)
            push_byte(8'($urandom), 1'b1);
        settle();

        for (int ph = 0; ph < 13; ph++)
            random_phase(90);

        if (mismatches == 0 && report_q.size() == 0)
            $display("wildcard_byte_pattern_scan_core verification clean");
        else
            $display("wildcard_byte_pattern_scan_core verification failed");
        $finish;
    end

endmodule
